// ===== src/sorted_marker_list_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted marker list assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_MARKER_LIST_MACROS_SVH
`define SORTED_MARKER_LIST_MACROS_SVH

`ifndef SYNTH
`define SML_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SML_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SML_ASSERT(lbl, prop, msg)
`define SML_NEVER(lbl, cond, msg)
`endif

`endif

// ===== src/sml_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted marker list package
// Sizes, cell operation codes and the control bundle shared by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sml_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int INDEX_W = 6;
	localparam int POS_W   = 17;
	localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	localparam logic [POS_W-1:0] POS_ONE = POS_W'(65536);

	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_INS  = 3'd1;
	localparam logic [2:0] OP_DEL  = 3'd2;
	localparam logic [2:0] OP_RDLD = 3'd3;
	localparam logic [2:0] OP_RDSH = 3'd4;

	typedef struct packed {
		logic [2:0]         op;
		logic [POS_W-1:0]   pos;
		logic [INDEX_W-1:0] idx;
		logic [CNT_W-1:0]   count;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== src/sml_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted marker list cell
// Holds one list entry and one read slot; shifts with its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module sml_cell (
	input  wire logic                       clk,
	input  wire logic [sml_pkg::IDX_W-1:0]  cell_idx,
	input  wire sml_pkg::ctrl_t             ctrl,
	input  wire logic [sml_pkg::POS_W-1:0]  prev_val,
	input  wire logic                       prev_gt,
	input  wire logic [sml_pkg::POS_W-1:0]  next_val,
	input  wire logic [sml_pkg::POS_W-1:0]  next_rd,
	output logic      [sml_pkg::POS_W-1:0]  val,
	output logic                            gt,
	output logic      [sml_pkg::POS_W-1:0]  rd
);

	logic [sml_pkg::POS_W-1:0] val_q;
	logic [sml_pkg::POS_W-1:0] rd_q;
	logic                      valid;
	logic                      at_or_above;
	logic                      hit;

	assign valid       = sml_pkg::CMP_W'(cell_idx) < sml_pkg::CMP_W'(ctrl.count);
	assign at_or_above = sml_pkg::CMP_W'(cell_idx) >= sml_pkg::CMP_W'(ctrl.idx);
	assign hit         = sml_pkg::CMP_W'(cell_idx) == sml_pkg::CMP_W'(ctrl.idx);
	assign gt          = !valid || (val_q > ctrl.pos);
	assign val         = val_q;
	assign rd          = rd_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			sml_pkg::OP_INS: begin
				if (prev_gt) begin
					val_q <= prev_val;
				end else if (gt) begin
					val_q <= ctrl.pos;
				end
			end
			sml_pkg::OP_DEL: begin
				if (at_or_above) begin
					val_q <= next_val;
				end
			end
			sml_pkg::OP_RDLD: begin
				rd_q <= hit ? val_q : '0;
			end
			sml_pkg::OP_RDSH: begin
				rd_q <= next_rd;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/sorted_marker_list.sv =====
// Add, remove, clear and unused actions pass from an execute state to a done state that loads
// the output register once it is free; a move adds an insert state after its delete, and a read
// adds a read state in which the read slot walks one cell a cycle. A request is taken only in idle.
// The request side stays ready while a finished result waits on the output register.
// Reset (arst_n, asynchronous) empties the list and the control; entry cells are not cleared.
// ----------------------------------------------------------------------------
// Sorted marker list
// Ascending list of clamped marker positions kept in a row of shifting cells.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_marker_list_macros.svh"

module sorted_marker_list (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [5:0] index, [23:6] position
	input  wire logic [2:0]  s_tuser,   // [2:0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [6:0] entry_count, [23:7] read_value
	output logic      [1:0]  m_tuser    // [1:0] status
);

	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_MOVE   = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_READ   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam int DEPTH = sml_pkg::DEPTH;
	localparam int POS_W = sml_pkg::POS_W;
	localparam int CNT_W = sml_pkg::CNT_W;
	localparam int IDX_W = sml_pkg::INDEX_W;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] rdcnt_q, rdcnt_d;
	logic [1:0]       status_q, status_d;
	logic [2:0]       act_q;
	logic [IDX_W-1:0] idx_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_clamped;
	logic             full;
	logic             range_bad;
	logic             load_out;
	logic             m_tvalid_q;
	logic [23:0]      m_tdata_q;
	logic [1:0]       m_tuser_q;
	logic [POS_W-1:0] rd_value;
	logic [2:0]       op;
	sml_pkg::ctrl_t   ctrl;

	logic [POS_W-1:0] val_w [DEPTH];
	logic             gt_w  [DEPTH];
	logic [POS_W-1:0] rd_w  [DEPTH];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		if (s_tdata[23]) begin
			pos_clamped = '0;
		end else if (s_tdata[22:6] > sml_pkg::POS_ONE) begin
			pos_clamped = sml_pkg::POS_ONE;
		end else begin
			pos_clamped = s_tdata[22:6];
		end
	end

	assign full      = (count_q == CNT_W'(DEPTH));
	assign range_bad = sml_pkg::CMP_W'(idx_q) >= sml_pkg::CMP_W'(count_q);
	assign load_out  = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
	assign rd_value  = ((act_q == ACT_READ) && (status_q == ST_DONE)) ? rd_w[0] : '0;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		rdcnt_d  = rdcnt_q;
		status_d = status_q;
		op       = sml_pkg::OP_HOLD;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = ST_DONE;
				state_d  = S_DONE;
				case (act_q)
					ACT_ADD: begin
						if (full) begin
							status_d = ST_FULL;
						end else begin
							op      = sml_pkg::OP_INS;
							count_d = count_q + 1'b1;
						end
					end
					ACT_MOVE: begin
						if (range_bad) begin
							status_d = ST_RANGE;
						end else begin
							op      = sml_pkg::OP_DEL;
							count_d = count_q - 1'b1;
							state_d = S_INS;
						end
					end
					ACT_REMOVE: begin
						if (range_bad) begin
							status_d = ST_RANGE;
						end else begin
							op      = sml_pkg::OP_DEL;
							count_d = count_q - 1'b1;
						end
					end
					ACT_READ: begin
						if (range_bad) begin
							status_d = ST_RANGE;
						end else begin
							op      = sml_pkg::OP_RDLD;
							rdcnt_d = idx_q;
							state_d = S_RD;
						end
					end
					ACT_CLEAR: begin
						count_d = '0;
					end
					default: begin
					end
				endcase
			end
			S_INS: begin
				op      = sml_pkg::OP_INS;
				count_d = count_q + 1'b1;
				state_d = S_DONE;
			end
			S_RD: begin
				if (rdcnt_q == '0) begin
					state_d = S_DONE;
				end else begin
					op      = sml_pkg::OP_RDSH;
					rdcnt_d = rdcnt_q - 1'b1;
				end
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl       = '0;
		ctrl.op    = op;
		ctrl.pos   = pos_q;
		ctrl.idx   = idx_q;
		ctrl.count = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			rdcnt_q    <= '0;
			status_q   <= ST_DONE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			rdcnt_q  <= rdcnt_d;
			status_q <= status_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q <= s_tuser;
			idx_q <= s_tdata[5:0];
			pos_q <= pos_clamped;
		end
		if (load_out) begin
			m_tdata_q <= {rd_value, 7'(count_q)};
			m_tuser_q <= status_q;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [POS_W-1:0] prev_val;
		logic             prev_gt;
		logic [POS_W-1:0] next_val;
		logic [POS_W-1:0] next_rd;

		if (g == 0) begin : g_first
			assign prev_val = '0;
			assign prev_gt  = 1'b0;
		end else begin : g_mid
			assign prev_val = val_w[g-1];
			assign prev_gt  = gt_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_val = '0;
			assign next_rd  = '0;
		end else begin : g_body
			assign next_val = val_w[g+1];
			assign next_rd  = rd_w[g+1];
		end

		sml_cell u_cell (
			.clk      (clk),
			.cell_idx (sml_pkg::IDX_W'(g)),
			.ctrl     (ctrl),
			.prev_val (prev_val),
			.prev_gt  (prev_gt),
			.next_val (next_val),
			.next_rd  (next_rd),
			.val      (val_w[g]),
			.gt       (gt_w[g]),
			.rd       (rd_w[g])
		);
	end

	`SML_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count beyond list depth")
	`SML_ASSERT(a_full_add_keeps, (state_q == S_EXEC && act_q == ACT_ADD && full) |=> $stable(count_q), "add to full list changed count")
	`SML_ASSERT(a_move_keeps, (state_q == S_EXEC && act_q == ACT_MOVE) |-> ##2 (count_q == $past(count_q, 2)), "move changed entry count")
	`SML_ASSERT(a_take_exec, (s_tvalid && s_tready) |=> (state_q == S_EXEC), "request taken without execution")
	`SML_NEVER(a_rd_done_early, state_q == S_RD && state_d == S_DONE && rdcnt_q != '0, "read left before slot reached cell zero")

endmodule

`default_nettype wire
